FILE: src/billboard_quad_corners_assert.svh
// Assertion helpers used by the RTL FIFO (bqc_fifo).
`ifndef BILLBOARD_QUAD_CORNERS_ASSERT_SVH
`define BILLBOARD_QUAD_CORNERS_ASSERT_SVH

// A property that must hold at every clock edge outside reset.
`define BQC_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// A condition that must be followed by another in the next cycle.
`define BQC_ASSERT_NEXT(lbl, clk, rst, pre, post, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);

`endif

FILE: src/bqc_pkg.sv
package bqc_pkg;

   localparam int RSQRT_STEPS_DEF = 3;
   localparam int IN_W = 16;
   localparam int NRM_W = 17;
   localparam int OUT_W = 24;
   localparam int HS_W = 16;
   localparam int CSR_ADDR_W = 1;
   localparam int CSR_DATA_W = 16;
   localparam int MID_DEPTH = 2;
   localparam int OUT_DEPTH = 4;

   localparam logic [CSR_ADDR_W-1:0] REG_HALF_SIZE = 1'd0;
   localparam logic [CSR_ADDR_W-1:0] REG_VERTICAL_MODE = 1'd1;
   localparam logic [HS_W-1:0] HALF_SIZE_RST = 16'd256;
   localparam logic signed [NRM_W-1:0] WORLD_UP_Y = 17'sd16384;

   typedef logic signed [IN_W-1:0] in_comp_type;
   typedef in_comp_type [2:0] in_vec_type;
   typedef logic signed [NRM_W-1:0] nrm_type;
   typedef nrm_type [2:0] nrm_vec_type;

   typedef struct packed {
      in_comp_type right_x;
      in_comp_type right_y;
      in_comp_type right_z;
      in_comp_type up_x;
      in_comp_type up_y;
      in_comp_type up_z;
   } req_type;

   typedef struct packed {
      logic signed [OUT_W-1:0] corner_x;
      logic signed [OUT_W-1:0] corner_y;
      logic signed [OUT_W-1:0] corner_z;
      logic tex_u;
      logic tex_v;
      logic [1:0] corner_index;
      logic degenerate;
      logic last_corner;
   } rsp_type;

   typedef struct packed {
      nrm_vec_type r;
      nrm_vec_type u;
      logic degen;
   } mid_type;

endpackage

FILE: src/billboard_quad_corners.sv
// The front normalizer pipeline buffers ahead of the corner stage and takes a new item every
// cycle unless a full mid queue stalls it. The corner stage emits one corner per cycle while
// an item waits and the output queue has room, and pops each item after its four corners.
// Reset is synchronous, active high: queues empty, half_size 256, vertical_mode 0.
// No clearing pass; the block accepts items in the cycle after reset.
module billboard_quad_corners #(
   parameter int RSQRT_STEPS = bqc_pkg::RSQRT_STEPS_DEF
) (
   input  logic clock,
   input  logic reset,
   input  logic req_push,
   output logic req_full,
   input  bqc_pkg::req_type req_data,
   output logic rsp_empty,
   input  logic rsp_pop,
   output bqc_pkg::rsp_type rsp_data,
   input  logic csr_wen,
   input  logic [bqc_pkg::CSR_ADDR_W-1:0] csr_addr,
   input  logic [bqc_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import bqc_pkg::*;

   logic [HS_W-1:0] half_size_ff;
   logic vertical_mode_ff;
   logic mq_push, mq_pop, mq_full, mq_empty;
   mid_type mq_in, mq_head;
   logic [$bits(mid_type)-1:0] mq_head_bits;
   logic oq_push, oq_full, oq_afull;
   rsp_type oq_in;
   logic [$bits(rsp_type)-1:0] oq_head_bits;

   always_ff @(posedge clock) begin
      if (reset) begin
         half_size_ff <= HALF_SIZE_RST;
         vertical_mode_ff <= 1'b0;
      end else if (csr_wen) begin
         case (csr_addr)
            REG_HALF_SIZE: begin
               half_size_ff <= csr_wdata[HS_W-1:0];
            end
            REG_VERTICAL_MODE: begin
               vertical_mode_ff <= csr_wdata[0];
            end
            default: begin
            end
         endcase
      end
   end

   bqc_front #(.RSQRT_STEPS(RSQRT_STEPS)) u_front (
      .clock(clock), .reset(reset),
      .req_push(req_push), .req_full(req_full), .req_data(req_data),
      .vertical_mode(vertical_mode_ff),
      .q_push(mq_push), .q_data(mq_in), .q_full(mq_full)
   );

   bqc_fifo #(.WIDTH($bits(mid_type)), .DEPTH(MID_DEPTH)) u_mid_q (
      .clock(clock), .reset(reset),
      .push(mq_push), .push_data(mq_in), .pop(mq_pop), .head(mq_head_bits),
      .full(mq_full), .afull(), .empty(mq_empty)
   );

   assign mq_head = mid_type'(mq_head_bits);

   bqc_back u_back (
      .clock(clock), .reset(reset),
      .q_empty(mq_empty), .q_data(mq_head), .q_pop(mq_pop),
      .half_size(half_size_ff),
      .o_full(oq_full), .o_afull(oq_afull), .o_push(oq_push), .o_data(oq_in)
   );

   bqc_fifo #(.WIDTH($bits(rsp_type)), .DEPTH(OUT_DEPTH)) u_out_q (
      .clock(clock), .reset(reset),
      .push(oq_push), .push_data(oq_in), .pop(rsp_pop), .head(oq_head_bits),
      .full(oq_full), .afull(oq_afull), .empty(rsp_empty)
   );

   assign rsp_data = rsp_type'(oq_head_bits);

endmodule

FILE: src/bqc_fifo.sv
`include "billboard_quad_corners_assert.svh"

module bqc_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  logic clock,
   input  logic reset,
   input  logic push,
   input  logic [WIDTH-1:0] push_data,
   input  logic pop,
   output logic [WIDTH-1:0] head,
   output logic full,
   output logic afull,
   output logic empty
);
   localparam int AW = $clog2(DEPTH);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [AW-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [AW:0] cnt_ff, cnt_in;
   logic do_push, do_pop;

   assign full = cnt_ff == (AW+1)'(DEPTH);
   assign afull = cnt_ff >= (AW+1)'(DEPTH - 1);
   assign empty = cnt_ff == '0;
   assign do_push = push && !full;
   assign do_pop = pop && !empty;
   assign head = mem[rd_ff];

   always_comb begin
      wr_in = do_push ? AW'(wr_ff + 1'b1) : wr_ff;
      rd_in = do_pop ? AW'(rd_ff + 1'b1) : rd_ff;
      cnt_in = cnt_ff;
      if (do_push && !do_pop) begin
         cnt_in = (AW+1)'(cnt_ff + 1'b1);
      end else if (do_pop && !do_push) begin
         cnt_in = (AW+1)'(cnt_ff - 1'b1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff <= '0;
         rd_ff <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff <= wr_in;
         rd_ff <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem[wr_ff] <= push_data;
      end
   end

   `BQC_ASSERT(a_cnt_bound, clock, reset, cnt_ff <= (AW+1)'(DEPTH), "fifo count over depth")
   `BQC_ASSERT(a_no_overflow, clock, reset, !(push && full), "push into a full fifo")
   `BQC_ASSERT_NEXT(a_cnt_up, clock, reset, do_push && !do_pop, cnt_ff == (AW+1)'($past(cnt_ff) + 1'b1), "fifo count did not grow")

endmodule

FILE: src/bqc_norm.sv
module bqc_norm #(
   parameter int STEPS = bqc_pkg::RSQRT_STEPS_DEF
) (
   input  logic clock,
   input  logic en,
   input  bqc_pkg::in_vec_type vec,
   output bqc_pkg::nrm_vec_type unit,
   output logic zero
);
   import bqc_pkg::*;

   localparam int NS = 6 + 3 * STEPS;
   localparam logic [31:0] THREE = 32'hC000_0000;
   localparam logic [31:0] Y_MAX = 32'h8000_0000;

   typedef struct packed {
      in_vec_type c;
      logic [31:0] x;
      logic [3:0] j;
      logic zero;
   } side_type;

   function automatic logic [15:0] mag16(input in_comp_type c);
      logic [15:0] u;
      u = c;
      return c[IN_W-1] ? 16'(~u + 16'd1) : u;
   endfunction

   function automatic logic [31:0] clamp_y(input logic [31:0] y);
      return (y > Y_MAX) ? Y_MAX : y;
   endfunction

   side_type side_ff [NS-1];
   logic [31:0] sq_ff [3];
   logic [31:0] len2_ff;
   logic [3:0] norm_j;
   logic [31:0] y_ff [STEPS+1];
   logic [31:0] ya_ff [STEPS];
   logic [32:0] y2_ff [STEPS];
   logic [31:0] yb_ff [STEPS];
   logic [31:0] d_ff [STEPS];
   logic [47:0] p_ff [3];
   nrm_vec_type unit_ff;
   logic zero_ff;

   assign unit = unit_ff;
   assign zero = zero_ff;

   // Shift count in pairs of bits that brings the squared length into [2^30, 2^32).
   always_comb begin
      norm_j = 4'd15;
      for (int k = 0; k < 16; k++) begin
         if (len2_ff[2*k +: 2] != 2'b00) begin
            norm_j = 4'(15 - k);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         side_ff[0] <= side_type'{c: vec, x: '0, j: '0, zero: 1'b0};
         for (int i = 0; i < 3; i++) begin
            sq_ff[i] <= 32'(mag16(vec[i])) * 32'(mag16(vec[i]));
         end
         len2_ff <= sq_ff[0] + sq_ff[1] + sq_ff[2];
         side_ff[1] <= side_ff[0];
         side_ff[2] <= side_type'{c: side_ff[1].c, x: len2_ff << {norm_j, 1'b0},
                                  j: norm_j, zero: len2_ff == '0};
         // Linear seed 2.25 - 1.25x in Q2.30.
         y_ff[0] <= 32'h9000_0000 - ((side_ff[2].x >> 2) + (side_ff[2].x >> 4));
      end
   end

   for (genvar k = 3; k < NS - 1; k++) begin : g_side
      always_ff @(posedge clock) begin
         if (en) begin
            side_ff[k] <= side_ff[k-1];
         end
      end
   end

   for (genvar s = 0; s < STEPS; s++) begin : g_step
      logic [64:0] xy_prod;
      logic [32:0] t_val;
      assign xy_prod = 65'(side_ff[4+3*s].x) * 65'(y2_ff[s]);
      assign t_val = xy_prod[64:32];
      always_ff @(posedge clock) begin
         if (en) begin
            ya_ff[s] <= clamp_y(y_ff[s]);
            y2_ff[s] <= 33'((64'(clamp_y(y_ff[s])) * 64'(clamp_y(y_ff[s]))) >> 30);
            yb_ff[s] <= ya_ff[s];
            d_ff[s] <= (t_val > 33'(THREE)) ? 32'd0 : 32'(33'(THREE) - t_val);
            y_ff[s+1] <= 32'((64'(yb_ff[s]) * 64'(d_ff[s])) >> 31);
         end
      end
   end

   always_ff @(posedge clock) begin
      logic [47:0] m;
      logic [16:0] m17;
      logic [5:0] sh;
      if (en) begin
         sh = 6'd32 - {2'b00, side_ff[NS-2].j};
         for (int i = 0; i < 3; i++) begin
            p_ff[i] <= 48'(mag16(side_ff[NS-3].c[i])) * 48'(clamp_y(y_ff[STEPS]));
            m = p_ff[i] >> sh;
            m17 = m[16:0];
            if (side_ff[NS-2].zero) begin
               unit_ff[i] <= '0;
            end else begin
               unit_ff[i] <= side_ff[NS-2].c[i][IN_W-1] ? nrm_type'(~m17 + 17'd1)
                                                        : nrm_type'(m17);
            end
         end
         zero_ff <= side_ff[NS-2].zero;
      end
   end

endmodule

FILE: src/bqc_front.sv
module bqc_front #(
   parameter int RSQRT_STEPS = bqc_pkg::RSQRT_STEPS_DEF
) (
   input  logic clock,
   input  logic reset,
   input  logic req_push,
   output logic req_full,
   input  bqc_pkg::req_type req_data,
   input  logic vertical_mode,
   output logic q_push,
   output bqc_pkg::mid_type q_data,
   input  logic q_full
);
   import bqc_pkg::*;

   localparam int NS = 6 + 3 * RSQRT_STEPS;

   logic [NS-1:0] vld_ff, vld_in;
   logic en;
   in_vec_type r_vec, u_vec;
   nrm_vec_type r_unit, u_unit;
   logic r_zero, u_zero;

   // The whole pipeline holds while a finished item cannot enter the queue.
   assign en = !(vld_ff[NS-1] && q_full);
   assign req_full = !en;
   assign q_push = vld_ff[NS-1] && !q_full;

   assign r_vec[0] = req_data.right_x;
   assign r_vec[1] = req_data.right_y;
   assign r_vec[2] = req_data.right_z;
   assign u_vec[0] = req_data.up_x;
   assign u_vec[1] = req_data.up_y;
   assign u_vec[2] = req_data.up_z;

   bqc_norm #(.STEPS(RSQRT_STEPS)) u_norm_r (
      .clock(clock), .en(en), .vec(r_vec), .unit(r_unit), .zero(r_zero)
   );

   bqc_norm #(.STEPS(RSQRT_STEPS)) u_norm_u (
      .clock(clock), .en(en), .vec(u_vec), .unit(u_unit), .zero(u_zero)
   );

   always_comb begin
      vld_in = en ? {vld_ff[NS-2:0], req_push} : vld_ff;
      q_data.r = r_unit;
      if (vertical_mode) begin
         q_data.u[0] = '0;
         q_data.u[1] = WORLD_UP_Y;
         q_data.u[2] = '0;
         q_data.degen = r_zero;
      end else begin
         q_data.u = u_unit;
         q_data.degen = r_zero || u_zero;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

endmodule

FILE: src/bqc_back.sv
module bqc_back (
   input  logic clock,
   input  logic reset,
   input  logic q_empty,
   input  bqc_pkg::mid_type q_data,
   output logic q_pop,
   input  logic [bqc_pkg::HS_W-1:0] half_size,
   input  logic o_full,
   input  logic o_afull,
   output logic o_push,
   output bqc_pkg::rsp_type o_data
);
   import bqc_pkg::*;

   function automatic logic [NRM_W:0] ext(input nrm_type v, input logic neg);
      logic [NRM_W:0] w;
      w = {v[NRM_W-1], v};
      return neg ? (NRM_W+1)'(~w + 1'b1) : w;
   endfunction

   logic [1:0] k_ff, k_in;
   logic a_vld_ff;
   logic adv;
   logic [32:0] prod_ff [3];
   logic [2:0] neg_ff;
   logic [1:0] ak_ff;
   logic degen_ff;

   // Room is counted for the corner already in the product stage.
   assign adv = !q_empty && !o_full && !(o_afull && a_vld_ff);
   assign q_pop = adv && (k_ff == 2'd3);
   assign k_in = adv ? 2'(k_ff + 1'b1) : k_ff;
   assign o_push = a_vld_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         k_ff <= '0;
         a_vld_ff <= 1'b0;
      end else begin
         k_ff <= k_in;
         a_vld_ff <= adv;
      end
   end

   // Corner k is su*up + sr*right with su negative on corners 2 and 3
   // and sr negative on corners 1 and 2.
   always_ff @(posedge clock) begin
      logic [NRM_W:0] s;
      logic [NRM_W-1:0] m;
      if (adv) begin
         for (int i = 0; i < 3; i++) begin
            s = (NRM_W+1)'(ext(q_data.u[i], k_ff[1]) + ext(q_data.r[i], k_ff[1] ^ k_ff[0]));
            m = s[NRM_W] ? NRM_W'(~s + 1'b1) : s[NRM_W-1:0];
            prod_ff[i] <= 33'(m) * 33'(half_size);
            neg_ff[i] <= s[NRM_W];
         end
         ak_ff <= k_ff;
         degen_ff <= q_data.degen;
      end
   end

   // The scaled magnitude stays below 2^23, so its negation fits the signed output without saturation.
   always_comb begin
      logic [OUT_W-1:0] c [3];
      logic [OUT_W-1:0] m;
      for (int i = 0; i < 3; i++) begin
         m = {1'b0, prod_ff[i][32:10]};
         c[i] = neg_ff[i] ? OUT_W'(~m + 1'b1) : m;
      end
      o_data.corner_x = c[0];
      o_data.corner_y = c[1];
      o_data.corner_z = c[2];
      o_data.tex_u = !ak_ff[1];
      o_data.tex_v = ak_ff[1] ^ ak_ff[0];
      o_data.corner_index = ak_ff;
      o_data.degenerate = degen_ff;
      o_data.last_corner = ak_ff == 2'd3;
   end

endmodule
